FILE: sv/dcnm_pkg.sv
// Package for the depth cluster nearest-mean unit.
// Holds field widths, register reset values and register indexes; no dependencies.
package dcnm_pkg;

	localparam int unsigned MAX_POINTS_DEF = 64;
	localparam int unsigned DEPTH_W        = 32;
	localparam int unsigned MINPTS_W       = 6;
	localparam int unsigned APB_ADDR_W     = 3;
	localparam int unsigned APB_DATA_W     = 32;

	localparam logic [DEPTH_W-1:0]  RADIUS_RST = 32'd6554;
	localparam logic [MINPTS_W-1:0] MINPTS_RST = 6'd3;

	// Register index, taken from paddr bit 2.
	typedef enum logic {
		REG_RADIUS = 1'b0,
		REG_MINPTS = 1'b1
	} reg_idx_t;

endpackage

FILE: sv/dcnm_if.sv
// Valid/ready channel interfaces for samples in and results out.
// Depends on dcnm_pkg for field widths.
interface dcnm_in_if import dcnm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DEPTH_W-1:0] depth_sample;
	logic               last_point;
	modport source(output valid, depth_sample, last_point, input ready);
	modport sink(input valid, depth_sample, last_point, output ready);
endinterface

interface dcnm_out_if import dcnm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DEPTH_W-1:0] nearest_mean;
	logic               cluster_found;
	modport source(output valid, nearest_mean, cluster_found, input ready);
	modport sink(input valid, nearest_mean, cluster_found, output ready);
endinterface

FILE: sv/depth_cluster_nearest_mean_unit.sv
// Depth cluster nearest-mean unit: loads depth samples, then runs 1-D DBSCAN.
// Loading takes one sample per cycle while idle. After the last sample, neighbour
// counting and the expansion of each core point share one distance compare unit,
// with a seek step per point; each cluster mean comes from a serial divider.
// Input is not ready again until the result is registered. Reset (arst_n,
// asynchronous) restores the register defaults.
module depth_cluster_nearest_mean_unit import dcnm_pkg::*; #(
	parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dcnm_in_if.sink               samples,
	dcnm_out_if.source            result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);
	localparam int unsigned IW  = $clog2(MAX_POINTS);
	localparam int unsigned TW  = $clog2(MAX_POINTS + 1);
	localparam int unsigned SW  = DEPTH_W + IW;
	localparam int unsigned DCW = $clog2(SW + 1);
	localparam int unsigned CW  = (TW > MINPTS_W) ? TW : MINPTS_W;

	typedef enum logic [10:0] {
		ST_IDLE     = 11'b00000000001,
		ST_CNT_LD   = 11'b00000000010,
		ST_CNT_HOLD = 11'b00000000100,
		ST_CNT      = 11'b00000001000,
		ST_SEEK     = 11'b00000010000,
		ST_POP      = 11'b00000100000,
		ST_PADDR    = 11'b00001000000,
		ST_PHOLD    = 11'b00010000000,
		ST_EXP      = 11'b00100000000,
		ST_DIV      = 11'b01000000000,
		ST_OUT      = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [DEPTH_W-1:0]  radius_q;
	logic [MINPTS_W-1:0] minpts_q;
	logic [TW-1:0]       total_q, n_q, j_q, cnt_q, head_q, tail_q, size_q;
	logic [IW-1:0]       i_q, jd_s1;
	logic                vld_s1;
	logic [DEPTH_W-1:0]  base_q, best_q;
	logic                found_q;
	logic [SW-1:0]       sum_q;
	logic [TW-1:0]       rem_q;
	logic [DCW-1:0]      dcnt_q;
	logic [MAX_POINTS-1:0] core_q, visited_q;
	logic [DEPTH_W-1:0]  res_mean_q;
	logic                res_found_q, res_valid_q;

	// APB configuration port.
	logic cfg_wr;
	reg_idx_t cfg_idx;
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = (cfg_idx == REG_MINPTS) ? APB_DATA_W'(minpts_q) : APB_DATA_W'(radius_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			minpts_q <= MINPTS_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_RADIUS: radius_q <= pwdata[DEPTH_W-1:0];
				REG_MINPTS: minpts_q <= pwdata[MINPTS_W-1:0];
				default: ;
			endcase
		end
	end

	// Sample and queue memories.
	logic               in_xfer, dep_we, q_we;
	logic [IW-1:0]      dep_raddr, q_waddr, q_wdata, q_rdata;
	logic [DEPTH_W-1:0] dep_rdata;

	assign samples.ready = (state_q == ST_IDLE);
	assign in_xfer = samples.valid && samples.ready;
	assign dep_we  = in_xfer && (total_q < TW'(MAX_POINTS));

	dcnm_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_POINTS)) u_depth_ram (
		.clk(clk), .we(dep_we), .waddr(total_q[IW-1:0]), .wdata(samples.depth_sample),
		.raddr(dep_raddr), .rdata(dep_rdata)
	);

	dcnm_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_queue_ram (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(head_q[IW-1:0]), .rdata(q_rdata)
	);

	always_comb begin
		case (state_q)
			ST_CNT_LD:   dep_raddr = i_q;
			ST_PADDR:    dep_raddr = q_rdata;
			ST_CNT_HOLD,
			ST_PHOLD,
			ST_CNT,
			ST_EXP:      dep_raddr = j_q[IW-1:0];
			default:     dep_raddr = i_q;
		endcase
	end

	// Shared distance compare unit.
	logic [DEPTH_W-1:0] abs_diff;
	logic near;
	assign abs_diff = (base_q > dep_rdata) ? (base_q - dep_rdata) : (dep_rdata - base_q);
	assign near = abs_diff < radius_q;

	logic last_j, last_i, issue, cnt_hit, push;
	logic [TW-1:0] cnt_nx, tail_nx;
	assign last_j  = vld_s1 && (TW'(jd_s1) == n_q - 1'b1);
	assign last_i  = (TW'(i_q) == n_q - 1'b1);
	assign issue   = (j_q < n_q);
	assign cnt_hit = vld_s1 && near && (jd_s1 != i_q);
	assign cnt_nx  = cnt_q + TW'(cnt_hit);
	assign push    = (state_q == ST_EXP) && vld_s1 && core_q[jd_s1] && !visited_q[jd_s1] && near;
	assign tail_nx = tail_q + TW'(push);

	always_comb begin
		q_we    = 1'b0;
		q_waddr = tail_q[IW-1:0];
		q_wdata = jd_s1;
		if (state_q == ST_SEEK) begin
			q_we    = core_q[i_q] && !visited_q[i_q];
			q_waddr = '0;
			q_wdata = i_q;
		end else if (push) begin
			q_we = 1'b1;
		end
	end

	// One restoring division step per cycle.
	logic [TW:0]    trial;
	logic           qbit;
	logic [SW-1:0]  sum_sh;
	assign trial  = {rem_q, sum_q[SW-1]};
	assign qbit   = (trial >= {1'b0, size_q});
	assign sum_sh = {sum_q[SW-2:0], qbit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			jd_s1       <= '0;
			vld_s1      <= 1'b0;
			cnt_q       <= '0;
			base_q      <= '0;
			sum_q       <= '0;
			size_q      <= '0;
			rem_q       <= '0;
			core_q      <= '0;
			visited_q   <= '0;
			found_q     <= 1'b0;
			best_q      <= '1;
			res_valid_q <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			dcnt_q      <= '0;
		end else begin
			if (result.ready && state_q != ST_OUT) begin
				res_valid_q <= 1'b0;
			end
			if (state_q == ST_CNT_HOLD || state_q == ST_PHOLD || state_q == ST_CNT
					|| state_q == ST_EXP) begin
				vld_s1 <= issue;
				jd_s1  <= j_q[IW-1:0];
				if (issue) begin
					j_q <= j_q + 1'b1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (samples.last_point) begin
							n_q       <= dep_we ? total_q + 1'b1 : total_q;
							total_q   <= '0;
							i_q       <= '0;
							visited_q <= '0;
							found_q   <= 1'b0;
							best_q    <= '1;
							state_q   <= ST_CNT_LD;
						end else if (dep_we) begin
							total_q <= total_q + 1'b1;
						end
					end
				end
				ST_CNT_LD: begin
					cnt_q   <= '0;
					j_q     <= '0;
					state_q <= ST_CNT_HOLD;
				end
				ST_CNT_HOLD: begin
					base_q  <= dep_rdata;
					state_q <= ST_CNT;
				end
				ST_CNT: begin
					cnt_q <= cnt_nx;
					if (last_j) begin
						core_q[i_q] <= (CW'(cnt_nx) >= CW'(minpts_q));
						if (last_i) begin
							i_q     <= '0;
							state_q <= ST_SEEK;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_CNT_LD;
						end
					end
				end
				ST_SEEK: begin
					if (core_q[i_q] && !visited_q[i_q]) begin
						visited_q[i_q] <= 1'b1;
						head_q  <= '0;
						tail_q  <= TW'(1);
						sum_q   <= '0;
						size_q  <= '0;
						state_q <= ST_POP;
					end else if (last_i) begin
						state_q <= ST_OUT;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_POP: begin
					head_q  <= head_q + 1'b1;
					state_q <= ST_PADDR;
				end
				ST_PADDR: begin
					j_q     <= '0;
					state_q <= ST_PHOLD;
				end
				ST_PHOLD: begin
					base_q  <= dep_rdata;
					sum_q   <= sum_q + SW'(dep_rdata);
					size_q  <= size_q + 1'b1;
					state_q <= ST_EXP;
				end
				ST_EXP: begin
					if (push) begin
						visited_q[jd_s1] <= 1'b1;
					end
					tail_q <= tail_nx;
					if (last_j) begin
						if (head_q == tail_nx) begin
							rem_q   <= '0;
							dcnt_q  <= DCW'(SW);
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_POP;
						end
					end
				end
				ST_DIV: begin
					rem_q  <= qbit ? TW'(trial - {1'b0, size_q}) : trial[TW-1:0];
					sum_q  <= sum_sh;
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == DCW'(1)) begin
						// Earliest cluster wins ties, so only a strictly smaller mean replaces.
						if (!found_q || (sum_sh[DEPTH_W-1:0] < best_q)) begin
							best_q  <= sum_sh[DEPTH_W-1:0];
							found_q <= 1'b1;
						end
						if (last_i) begin
							state_q <= ST_OUT;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_SEEK;
						end
					end
				end
				ST_OUT: begin
					if (!res_valid_q || result.ready) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!res_valid_q || result.ready)) begin
			res_mean_q  <= found_q ? best_q : '0;
			res_found_q <= found_q;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.nearest_mean  = res_mean_q;
	assign result.cluster_found = res_found_q;

`ifndef SYNTHESIS
	a_visited_core: assert property (@(posedge clk) disable iff (!arst_n)
		(visited_q & ~core_q) == '0)
		else $error("visited point is not a core point");
	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q && tail_q <= TW'(MAX_POINTS))
		else $error("expansion queue pointers out of order");
	a_no_cluster_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.cluster_found) |-> (result.nearest_mean == '0))
		else $error("mean must be zero when no cluster exists");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (dcnt_q != '0))
		else $error("divider step count underflow");
`endif
endmodule

FILE: sv/dcnm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dcnm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: dv/tb_depth_cluster_nearest_mean_unit.sv
// Testbench for the depth cluster nearest-mean unit: directed table, then random sets.
// Results are checked against a behavioral 1-D DBSCAN predictor in this file.
// Depends on dcnm_pkg, the channel interfaces in dcnm_if.sv and the unit itself.
`timescale 1ns / 100ps

module tb_depth_cluster_nearest_mean_unit;
	import dcnm_pkg::*;

	localparam int NPTS = MAX_POINTS_DEF;
	localparam int WATCHDOG_LIMIT = 400000;

	typedef struct {
		logic [31:0] depth;
		logic        last;
		logic        has_exp;
		logic [31:0] exp_mean;
		logic        exp_found;
	} stim_row_t;

	typedef struct {
		logic [31:0] mean;
		logic        found;
	} mean_result_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata, prdata;

	dcnm_in_if  samples();
	dcnm_out_if result();

	depth_cluster_nearest_mean_unit i_dut (
		.clk(clk), .arst_n(arst_n), .samples(samples), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor state.
	logic [31:0] radius;
	logic [5:0]  min_nb;
	logic [31:0] held_depths[NPTS];
	int          held_count;

	mean_result_t expected_means[$];
	int   fail_count;
	int   idle_cycles;
	int   send_gap_pct, recv_stall_pct;
	logic sending_done;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic depths_near(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = (a > b) ? a - b : b - a;
		return d < radius;
	endfunction

	function automatic mean_result_t nearest_cluster_mean();
		mean_result_t r;
		logic core[NPTS];
		logic seen[NPTS];
		int fifo[$];
		int cnt, p;
		logic [37:0] sum;
		logic [31:0] m;
		int members;
		r.mean = '0;
		r.found = 1'b0;
		for (int i = 0; i < held_count; i++) begin
			cnt = 0;
			for (int j = 0; j < held_count; j++)
				if (j != i && depths_near(held_depths[i], held_depths[j]))
					cnt++;
			core[i] = (cnt >= min_nb);
			seen[i] = 1'b0;
		end
		for (int i = 0; i < held_count; i++) begin
			if (!core[i] || seen[i])
				continue;
			seen[i] = 1'b1;
			fifo = {i};
			sum = '0;
			members = 0;
			while (fifo.size() > 0) begin
				p = fifo.pop_front();
				sum += held_depths[p];
				members++;
				for (int j = 0; j < held_count; j++)
					if (!seen[j] && core[j] && depths_near(held_depths[p], held_depths[j])) begin
						seen[j] = 1'b1;
						fifo = {fifo, j};
					end
			end
			m = 32'(sum / members);
			if (!r.found || m < r.mean) begin
				r.mean = m;
				r.found = 1'b1;
			end
		end
		return r;
	endfunction

	// Feeds one accepted sample to the predictor; returns 1 with a result on the last one.
	function automatic logic take_sample(logic [31:0] d, logic last, output mean_result_t r);
		if (held_count < NPTS) begin
			held_depths[held_count] = d;
			held_count++;
		end
		if (!last)
			return 1'b0;
		r = nearest_cluster_mean();
		held_count = 0;
		return 1'b1;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_RADIUS)
			radius = value;
		else
			min_nb = value[5:0];
	endtask

	// Waits for all results, then for the longest clustering run to drain.
	task automatic wait_idle();
		while (expected_means.size() > 0)
			@(posedge clk);
		repeat (NPTS * (NPTS + 3) + NPTS * (NPTS + 4) + 64 * 40 + 100)
			@(posedge clk);
	endtask

	// Sends one sample and waits for its transfer; checks an explicit expectation if given.
	// Valid stays high after a transfer so that the next sample can follow at once; it is
	// dropped in idle cycles and after the last sample of a set.
	task automatic send_sample(stim_row_t row);
		mean_result_t r;
		while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid        <= 1'b1;
		samples.depth_sample <= row.depth;
		samples.last_point   <= row.last;
		@(posedge clk);
		while (!samples.ready)
			@(posedge clk);
		if (take_sample(row.depth, row.last, r)) begin
			if (row.has_exp && (r.mean !== row.exp_mean || r.found !== row.exp_found)) begin
				$error("table row disagrees with predictor: nearest_mean exp %0h got %0h",
					row.exp_mean, r.mean);
				fail_count++;
			end
			expected_means = {expected_means, r};
		end
		if (row.last) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_set(int n, logic [31:0] base, logic [31:0] spread);
		stim_row_t row;
		row.has_exp = 1'b0;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(9))
				0:       row.depth = $urandom();
				1:       row.depth = 32'hFFFF_FFFF - $urandom_range(spread);
				default: row.depth = base + $urandom_range(spread);
			endcase
			row.last = (k == n - 1);
			send_sample(row);
		end
	endtask

	// Receiver: random stalls, compares every result transfer with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		mean_result_t e;
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_means.size() == 0) begin
					$error("result transfer with no expectation: nearest_mean %0h",
						result.nearest_mean);
					fail_count++;
				end else begin
					e = expected_means.pop_front();
					if (result.nearest_mean !== e.mean) begin
						$error("nearest_mean exp %0h got %0h", e.mean, result.nearest_mean);
						fail_count++;
					end
					if (result.cluster_found !== e.found) begin
						$error("cluster_found exp %0b got %0b", e.found, result.cluster_found);
						fail_count++;
					end
				end
			end
			result.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((samples.valid && samples.ready) || (result.valid && result.ready) || sending_done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	stim_row_t directed_rows[$];

	function automatic stim_row_t mk(logic [31:0] d, logic last, logic he = 1'b0,
		logic [31:0] em = '0, logic ef = 1'b0);
		stim_row_t r;
		r.depth = d; r.last = last; r.has_exp = he; r.exp_mean = em; r.exp_found = ef;
		return r;
	endfunction

	initial begin
		int pts, sent;
		arst_n = 1'b0;
		samples.valid = 1'b0;
		samples.depth_sample = '0;
		samples.last_point = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		radius = RADIUS_RST;
		min_nb = MINPTS_RST;
		held_count = 0;
		fail_count = 0;
		idle_cycles = 0;
		sending_done = 1'b0;
		send_gap_pct = 10;
		recv_stall_pct = 68;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: single point is not core, so no cluster.
		directed_rows = {directed_rows, mk(32'h0001_0000, 1'b1, 1'b1, 32'd0, 1'b0)};
		// Four equal points at the top of the range form one cluster.
		for (int k = 0; k < 4; k++)
			directed_rows = {directed_rows,
				mk(32'hFFFF_FFFF, k == 3, k == 3, 32'hFFFF_FFFF, 1'b1)};
		// Four equal zeros, plus a distant noise point.
		for (int k = 0; k < 4; k++)
			directed_rows = {directed_rows, mk(32'd0, 1'b0)};
		directed_rows = {directed_rows, mk(32'h8000_0000, 1'b1, 1'b1, 32'd0, 1'b1)};
		// Two clusters; the smaller mean wins.
		for (int k = 0; k < 4; k++)
			directed_rows = {directed_rows, mk(32'h0005_0000 + k, 1'b0)};
		for (int k = 0; k < 4; k++)
			directed_rows = {directed_rows, mk(32'h0002_0000 + k, k == 3)};
		foreach (directed_rows[k])
			send_sample(directed_rows[k]);

		// Overflow: more than a full set, the dropped last sample still closes it.
		for (int k = 0; k < NPTS + 3; k++)
			send_sample(mk(32'h0003_0000 + 32'(k % 5), k == NPTS + 2));
		wait_idle();

		// Zero neighbours needed: every point is its own cluster at zero radius.
		write_reg(REG_MINPTS, 32'd0);
		write_reg(REG_RADIUS, 32'd0);
		send_sample(mk(32'h7000_0000, 1'b0));
		send_sample(mk(32'h1234_5678, 1'b0));
		send_sample(mk(32'hFFFF_FFFF, 1'b1, 1'b1, 32'h1234_5678, 1'b1));
		wait_idle();
		write_reg(REG_MINPTS, 32'd63);
		write_reg(REG_RADIUS, 32'hFFFF_FFFF);
		send_set(NPTS, 32'd0, 32'hFFFF_FFFF);
		send_set(NPTS, 32'h4000_0000, 32'd100);
		wait_idle();

		sent = 0;
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				send_gap_pct = 68;
				recv_stall_pct = 10;
			end else if (phase == 2) begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			for (int s = 0; s < 4; s++) begin
				wait_idle();
				write_reg(REG_RADIUS, $urandom_range(3) == 0 ? $urandom() : $urandom_range(20000));
				write_reg(REG_MINPTS, $urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(4));
				repeat (6) begin
					pts = ($urandom_range(9) == 0) ? $urandom_range(NPTS + 2, 40)
						: $urandom_range(12, 1);
					send_set(pts, $urandom(), $urandom_range(3) == 0 ? $urandom() : 32'd40000);
					sent += pts;
				end
				if (sent > 1000)
					break;
			end
		end

		wait_idle();
		sending_done = 1'b1;
		if (fail_count == 0 && expected_means.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
